// ===== rtl/core/pfa_pkg.sv =====
package pfa_pkg;

	localparam int PARTITIONS = 16;
	localparam int SIZE_BITS  = 16;
	localparam int FIELD_W    = 16;

	localparam int IDX_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
	localparam int CNT_W = $clog2(PARTITIONS + 1);

	localparam logic [1:0] MODE_FIRST  = 2'd0;
	localparam logic [1:0] MODE_BEST   = 2'd1;
	localparam logic [1:0] MODE_WORST  = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_PLACE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} pfa_state_t;

endpackage

// ===== rtl/core/partition_fit_allocator.sv =====
// Fixed-partition allocator with first, best and worst fit placement.
// Input stream (s_*): one request per beat. s_tuser[0] = 0 loads a free
// partition of size s_tdata; loads beyond the table capacity are dropped.
// s_tuser[0] = 1 places a process of size s_tdata.
// Output stream (m_*): one result per place request, none for a load.
// Configuration: cfg_we writes cfg_wdata into the fit mode register
// (0 first fit, 1 best fit, 2 worst fit, 3 as first fit); write it only
// while the block is idle.
// Timing: a load is written into the table when it is accepted. A place
// request walks the loaded entries through one table read port and one
// comparator, one entry a cycle, and then loads the result register, at
// which point the chosen entry is also rewritten.
// s_tready is low while a place request is in progress; the next request
// is taken once the block is back in idle.
// The result register holds until taken; a request that finishes while the
// previous result is still waiting stalls in its last step.
// Reset empties the table, clears the request number and selects first fit.
module partition_fit_allocator
	import pfa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] size_value
	input  logic [0:0]  s_tuser,   // [0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [15:0] request_number, [31:16] chosen_size,
	                               // [47:32] left_size
	output logic [0:0]  m_tuser,   // [0] placed
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata
);

	logic [SIZE_BITS-1:0] mem [PARTITIONS];

	pfa_state_t state_q, state_nx;

	logic [1:0]           mode_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [FIELD_W-1:0]   req_num_q;
	logic [SIZE_BITS-1:0] size_q;
	logic [CNT_W-1:0]     issue_q;
	logic                 cmp_v_s1;
	logic [IDX_W-1:0]     cmp_idx_s1;
	logic [SIZE_BITS-1:0] rd_data_s1;
	logic                 found_q;
	logic [IDX_W-1:0]     pick_q;
	logic [SIZE_BITS-1:0] best_q;

	logic                 out_v_q;
	logic                 out_placed_q;
	logic [FIELD_W-1:0]   out_num_q;
	logic [FIELD_W-1:0]   out_chosen_q;
	logic [FIELD_W-1:0]   out_left_q;

	logic                 acc;
	logic                 issue_more;
	logic                 out_free;
	logic                 mem_we;
	logic [IDX_W-1:0]     mem_wa;
	logic [SIZE_BITS-1:0] mem_wd;
	logic [SIZE_BITS-1:0] in_size;
	logic [SIZE_BITS-1:0] left_val;
	logic                 hit;
	logic                 take;

	assign in_size    = s_tdata[SIZE_BITS-1:0];
	assign acc        = s_tvalid && s_tready;
	assign issue_more = (issue_q < cnt_q);
	assign out_free   = !out_v_q || m_tready;
	assign left_val   = best_q - size_q;

	// shared compare unit: one table entry per cycle
	assign hit = size_q < rd_data_s1;
	always_comb begin
		take = 1'b0;
		if (cmp_v_s1 && hit) begin
			if (!found_q) begin
				take = 1'b1;
			end else begin
				case (mode_q)
					MODE_BEST:  take = rd_data_s1 < best_q;
					MODE_WORST: take = rd_data_s1 > best_q;
					default:    take = 1'b0;
				endcase
			end
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && s_tuser[0] == REQ_PLACE) begin
					state_nx = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (!issue_more && !cmp_v_s1) begin
					state_nx = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		mem_we   = 1'b0;
		mem_wa   = pick_q;
		mem_wd   = left_val;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (acc && s_tuser[0] == REQ_LOAD && cnt_q < CNT_W'(PARTITIONS)) begin
					mem_we = 1'b1;
					mem_wa = cnt_q[IDX_W-1:0];
					mem_wd = in_size;
				end
			end
			ST_FINISH: begin
				mem_we = out_free && found_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_s1 <= mem[issue_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			mode_q    <= MODE_FIRST;
			cnt_q     <= '0;
			req_num_q <= '0;
			issue_q   <= '0;
			cmp_v_s1  <= 1'b0;
			found_q   <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			// load a finished result, else drop the one just taken
			if (state_q == ST_FINISH && out_free) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (s_tuser[0] == REQ_LOAD) begin
							if (cnt_q < CNT_W'(PARTITIONS)) begin
								cnt_q <= cnt_q + 1'b1;
							end
						end else begin
							req_num_q <= req_num_q + 1'b1;
							issue_q   <= '0;
							found_q   <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					cmp_v_s1 <= issue_more;
					if (issue_more) begin
						issue_q <= issue_q + 1'b1;
					end
					if (take) begin
						found_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && acc) begin
			size_q <= in_size;
		end
		if (state_q == ST_SCAN) begin
			cmp_idx_s1 <= issue_q[IDX_W-1:0];
			if (take) begin
				pick_q <= cmp_idx_s1;
				best_q <= rd_data_s1;
			end
		end
		if (state_q == ST_FINISH && out_free) begin
			out_placed_q <= found_q;
			out_num_q    <= req_num_q;
			out_chosen_q <= found_q ? FIELD_W'(best_q) : '0;
			out_left_q   <= found_q ? FIELD_W'(left_val) : '0;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_placed_q;
	assign m_tdata  = {out_left_q, out_chosen_q, out_num_q};

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(PARTITIONS))
		else $error("partition count beyond table capacity");

	a_pick_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(found_q && state_q != ST_IDLE) |-> (CNT_W'(pick_q) < cnt_q))
		else $error("chosen entry lies beyond the loaded entries");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (issue_q <= cnt_q))
		else $error("scan index ran past the loaded entries");

	a_placed_size: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata[31:16] != 16'd0 &&
		m_tdata[31:16] >= m_tdata[47:32]))
		else $error("placed result with inconsistent sizes");
`endif

endmodule

// ===== test/partition_fit_allocator_tb.sv =====
`timescale 1ns / 1ps

module partition_fit_allocator_tb;
	import pfa_pkg::*;

	localparam int DRAIN_CYCLES   = 24;
	localparam int STALL_LIMIT    = 2000;
	localparam int EMPTY_REQUESTS = 16;
	localparam int PHASE_PLACES   = 140;

	typedef struct packed {
		logic        placed;
		logic [15:0] number;
		logic [15:0] chosen;
		logic [15:0] left;
	} alloc_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_we;
	logic [1:0]  cfg_wdata;

	// allocator state as the block should hold it
	logic [SIZE_BITS-1:0] part_size [PARTITIONS];
	int                   part_count;
	logic [15:0]          request_count;
	logic [1:0]           fit_mode_now;

	alloc_result_t pending_results [$];
	int            mismatch_count;
	int            sender_idle_pct;
	int            receiver_stall_pct;
	int            quiet_cycles = 0;

	partition_fit_allocator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void predict_allocation(input logic kind, input logic [15:0] size);
		alloc_result_t r;
		logic          found;
		int            pick;
		found = 1'b0;
		pick  = 0;
		if (kind == REQ_LOAD) begin
			// drop loads once the table is full
			if (part_count < PARTITIONS) begin
				part_size[part_count] = size;
				part_count++;
			end
			return;
		end
		request_count++;
		for (int i = 0; i < part_count; i++) begin
			if (size < part_size[i]) begin
				if (!found) begin
					found = 1'b1;
					pick  = i;
					if (fit_mode_now != MODE_BEST && fit_mode_now != MODE_WORST)
						break;
				end else if (fit_mode_now == MODE_BEST && part_size[i] < part_size[pick]) begin
					pick = i;
				end else if (fit_mode_now == MODE_WORST && part_size[i] > part_size[pick]) begin
					pick = i;
				end
			end
		end
		r.placed = found;
		r.number = request_count;
		r.chosen = found ? part_size[pick] : '0;
		r.left   = found ? part_size[pick] - size : '0;
		if (found)
			part_size[pick] = r.left;
		pending_results.push_back(r);
	endfunction

	function automatic void compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// result checker and receiver stalls
	always @(posedge clk) begin
		alloc_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("request_number: expected none, got %0d", m_tdata[15:0]);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				compare_field("placed", want.placed, m_tuser[0]);
				compare_field("request_number", want.number, m_tdata[15:0]);
				compare_field("chosen_size", want.chosen, m_tdata[31:16]);
				compare_field("left_size", want.left, m_tdata[47:32]);
			end
		end
		m_tready <= ($urandom_range(1, 100) > receiver_stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("partition_fit_allocator_tb NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_request(input logic kind, input logic [15:0] size);
		while (sender_idle_pct != 0 && $urandom_range(1, 100) <= sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= size;
		s_tuser  <= kind;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_allocation(kind, size);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// a trailing load may still be in flight
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_fit_mode(input logic [1:0] mode);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_we <= 1'b0;
		fit_mode_now = mode;
	endtask

	function automatic logic [15:0] pick_request_size();
		int          roll;
		int          k;
		logic [16:0] near;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return 16'($urandom_range(0, 255));
		if (roll < 78 && part_count > 0) begin
			// aim just below, at or just above a partition
			k    = $urandom_range(0, part_count - 1);
			near = 17'(part_size[k]) + 17'($urandom_range(0, 2));
			if (near == 0)
				return '0;
			near = near - 17'd1;
			return (near > 17'hFFFF) ? 16'hFFFF : near[15:0];
		end
		if (roll < 90)
			return 16'($urandom_range(0, 65535));
		return 16'($urandom_range(16'hFFF0, 16'hFFFF));
	endfunction

	// empty table: nothing is placed, the request number still advances
	task automatic test_empty_table();
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		for (int n = 0; n < EMPTY_REQUESTS; n++)
			send_request(REQ_PLACE, 16'($urandom_range(0, 65535)));
	endtask

	task automatic test_directed_placement();
		set_fit_mode(MODE_FIRST);
		send_request(REQ_LOAD, 16'd0);
		send_request(REQ_LOAD, 16'd1);
		send_request(REQ_LOAD, 16'hFFFF);
		send_request(REQ_LOAD, 16'd300);
		send_request(REQ_LOAD, 16'd300);
		send_request(REQ_LOAD, 16'd40000);
		send_request(REQ_LOAD, 16'd40000);
		send_request(REQ_LOAD, 16'd7);
		send_request(REQ_LOAD, 16'd2);
		send_request(REQ_LOAD, 16'd1000);
		send_request(REQ_PLACE, 16'hFFFF);
		send_request(REQ_PLACE, 16'd0);
		send_request(REQ_PLACE, 16'd300);
		set_fit_mode(MODE_BEST);
		// equal candidates: earliest wins
		send_request(REQ_PLACE, 16'd299);
		send_request(REQ_PLACE, 16'd6);
		send_request(REQ_PLACE, 16'd40000);
		set_fit_mode(MODE_WORST);
		send_request(REQ_PLACE, 16'd10);
		send_request(REQ_PLACE, 16'd300);
		set_fit_mode(MODE_UNUSED);
		send_request(REQ_PLACE, 16'd0);
		// fill the table, then overflow it
		send_request(REQ_LOAD, 16'd32768);
		send_request(REQ_LOAD, 16'hFFFF);
		send_request(REQ_LOAD, 16'hFFFF);
		send_request(REQ_LOAD, 16'd1234);
		send_request(REQ_LOAD, 16'd5);
		send_request(REQ_LOAD, 16'd6);
		send_request(REQ_LOAD, 16'hAAAA);
		send_request(REQ_PLACE, 16'd5);
	endtask

	task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
	                                   input logic [1:0] first_mode);
		int places;
		for (int sub = 0; sub < 2; sub++) begin
			set_fit_mode(first_mode + 2'(sub));
			sender_idle_pct    = sender_pct;
			receiver_stall_pct = receiver_pct;
			places = 0;
			while (places < PHASE_PLACES) begin
				if ($urandom_range(0, 99) < 8) begin
					send_request(REQ_LOAD, 16'($urandom_range(0, 65535)));
				end else begin
					send_request(REQ_PLACE, pick_request_size());
					places++;
				end
			end
			sender_idle_pct    = 0;
			receiver_stall_pct = 0;
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= REQ_LOAD;
		cfg_we    <= 1'b0;
		cfg_wdata <= MODE_FIRST;
		part_count         = 0;
		request_count      = '0;
		fit_mode_now       = MODE_FIRST;
		mismatch_count     = 0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		for (int i = 0; i < PARTITIONS; i++)
			part_size[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_directed_placement();
		test_random_traffic(0, 0, MODE_FIRST);
		test_random_traffic(51, 0, MODE_WORST);
		test_random_traffic(0, 51, MODE_FIRST);
		test_random_traffic(9, 9, MODE_WORST);

		wait_idle();
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			mismatch_count++;
		end
		if (mismatch_count == 0) begin
			$display("partition_fit_allocator_tb OK");
		end else begin
			$display("partition_fit_allocator_tb NOT OK");
		end
		$finish;
	end

endmodule
